FILE: design/mhd_pkg.sv
// ----------------------------------------------------------------------------
// mhd_pkg: shared types, constants and tables of the harmonic DFT block
// Holds the beat types of both channels, the queue entry, the frame sums and
// the twiddle and phase-step tables that are built at elaboration.
// ----------------------------------------------------------------------------
package mhd_pkg;

   // Frame geometry: NSAMPLES points on the circle, both ends included.
   localparam int NSAMPLES = 51;
   localparam int NSPAN    = NSAMPLES - 1;
   localparam int PHASE_W  = $clog2(NSPAN);
   localparam int CNT_W    = $clog2(NSPAN + 1);

   // Datapath widths.
   localparam int SAMPLE_W   = 24;
   localparam int TW_W       = 16;
   localparam int PROD_W     = SAMPLE_W + TW_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int TERM_W     = SUM_W + 1;
   localparam int ACC_W      = 48;
   localparam int OUT_W      = 24;
   localparam int ORDER_W    = 5;
   localparam int ORDER_VALS = 1 << ORDER_W;
   localparam int TW_DEPTH   = 1 << PHASE_W;

   // Decoupling queue between the front and back parts.
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   // Final scaling: divide by 2*NSPAN*2^15 = NSPAN*2^16, rounding half away.
   localparam int RND_SHIFT = 16;
   localparam int QUOT_W    = ACC_W - RND_SHIFT;
   localparam logic [ACC_W-1:0]  RND_BIAS = ACC_W'(NSPAN) << (RND_SHIFT - 1);
   localparam logic [QUOT_W-1:0] SPAN_Q   = QUOT_W'(NSPAN);
   localparam logic [QUOT_W-1:0] RECIP    = QUOT_W'((64'd1 << QUOT_W) / 64'(NSPAN));

   // Saturation limits.
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [QUOT_W-1:0] OUT_POS_LIM = QUOT_W'((1 << (OUT_W - 1)) - 1);
   localparam logic [QUOT_W-1:0] OUT_NEG_LIM = QUOT_W'(1 << (OUT_W - 1));

   // Fixed-point constants of the twiddle series (Q2.30).
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [63:0] PI4_Q30 = 64'd843314857;
   localparam logic [63:0] SPAN64  = 64'(NSPAN);

   typedef logic [ORDER_W-1:0] order_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] bx_sample;
      logic signed [SAMPLE_W-1:0] by_sample;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] an_coef;
      logic signed [OUT_W-1:0] bn_coef;
   } rsp_type;

   // One classified sample as it waits for the multiply-accumulate.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] bx;
      logic signed [SAMPLE_W-1:0] by;
      logic signed [TW_W-1:0]     tw_cos;
      logic signed [TW_W-1:0]     tw_sin;
      logic                       dbl;
      logic                       last;
   } entry_type;

   // Completed frame sums handed to the scaler.
   typedef struct packed {
      logic signed [ACC_W-1:0] sum_imag;
      logic signed [ACC_W-1:0] sum_real;
   } frame_type;

   typedef logic [TW_DEPTH-1:0][2*TW_W-1:0]  tw_table_type;
   typedef logic [ORDER_VALS-1:0][PHASE_W-1:0] step_table_type;

   // Round a Q30 magnitude to Q15, half up, clipped to the largest Q1.15 value.
   function automatic logic [TW_W-1:0] q30_to_q15(logic [63:0] v);
      logic [63:0] r;
      r = (v + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return TW_W'(r);
   endfunction

   // Cosine and sine of 2*pi*p/NSPAN, packed as {cos, sin}.
   function automatic logic [2*TW_W-1:0] twiddle_entry(logic [63:0] p);
      logic [63:0] q;
      logic [63:0] oct;
      logic [63:0] r;
      logic [63:0] rr;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic signed [TW_W-1:0] s;
      logic signed [TW_W-1:0] c;
      logic signed [TW_W-1:0] co;
      logic signed [TW_W-1:0] so;
      q   = 64'd8 * p;
      oct = (q / SPAN64) & 64'd7;
      r   = q % SPAN64;
      rr  = oct[0] ? SPAN64 - r : r;
      x   = (PI4_Q30 * rr + SPAN64 / 64'd2) / SPAN64;
      x2  = (x * x) >> 30;
      t   = ONE_Q30 - x2 / 64'd42;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s   = q30_to_q15((x * t) >> 30);
      t   = ONE_Q30 - x2 / 64'd30;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
      c   = q30_to_q15(ONE_Q30 - ((x2 * t) >> 30) / 64'd2);
      case (oct[2:0])
         3'd0: begin co = c;  so = s;  end
         3'd1: begin co = s;  so = c;  end
         3'd2: begin co = -s; so = c;  end
         3'd3: begin co = -c; so = s;  end
         3'd4: begin co = -c; so = -s; end
         3'd5: begin co = -s; so = -c; end
         3'd6: begin co = s;  so = -c; end
         default: begin co = c; so = -s; end
      endcase
      return {co, so};
   endfunction

   function automatic tw_table_type build_tw_table();
      tw_table_type tbl;
      tbl = '0;
      for (int p = 0; p < NSPAN; p++) begin
         tbl[PHASE_W'(p)] = twiddle_entry(64'(p));
      end
      return tbl;
   endfunction

   // Phase advance per sample for each harmonic order: (n - 1) mod NSPAN.
   function automatic step_table_type build_step_table();
      step_table_type tbl;
      tbl = '0;
      for (int n = 0; n < ORDER_VALS; n++) begin
         tbl[ORDER_W'(n)] = PHASE_W'((n + NSPAN - 1) % NSPAN);
      end
      return tbl;
   endfunction

   localparam tw_table_type   TW_TABLE   = build_tw_table();
   localparam step_table_type STEP_TABLE = build_step_table();

endpackage

FILE: design/mhd_front.sv
// ----------------------------------------------------------------------------
// mhd_front: sample intake and classification
// Holds the harmonic order register, tracks the sample index and twiddle
// phase of the frame, and pushes each sample with its twiddle and weight.
// ----------------------------------------------------------------------------
module mhd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhd_pkg::req_type  req_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  mhd_pkg::order_type csr_data,
   input  logic              queue_full,
   output logic              push,
   output mhd_pkg::entry_type push_data
);
   import mhd_pkg::*;

   order_type          order_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [PHASE_W-1:0] step;
   logic [PHASE_W:0]   phase_sum;
   logic [2*TW_W-1:0]  tw_word;
   logic               first_sample;
   logic               last_sample;

   // The register port never pushes back.
   assign csr_ready = 1'b1;

   // A beat is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the sample and look up its twiddle.
   always_comb begin
      first_sample = (count_ff == '0);
      last_sample  = (count_ff == CNT_W'(NSPAN));
      step         = STEP_TABLE[order_ff];
      phase_sum    = {1'b0, phase_ff} + {1'b0, step};
      if (phase_sum >= (PHASE_W + 1)'(NSPAN)) begin
         phase_sum = phase_sum - (PHASE_W + 1)'(NSPAN);
      end
      tw_word          = TW_TABLE[phase_ff];
      push_data.bx     = req_data.bx_sample;
      push_data.by     = req_data.by_sample;
      push_data.tw_cos = tw_word[2*TW_W-1:TW_W];
      push_data.tw_sin = tw_word[TW_W-1:0];
      push_data.dbl    = !(first_sample || last_sample);
      push_data.last   = last_sample;
   end

   // Advance the frame position on every accepted beat.
   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      if (push) begin
         if (last_sample) begin
            count_in = '0;
            phase_in = '0;
         end else begin
            count_in = count_ff + 1'b1;
            phase_in = phase_sum[PHASE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_W'(1);
         count_ff <= '0;
         phase_ff <= '0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         if (csr_valid && csr_ready) begin
            order_ff <= csr_data;
         end
      end
   end

endmodule

FILE: design/mhd_queue.sv
// ----------------------------------------------------------------------------
// mhd_queue: short queue between the front and back parts
// A small circular buffer that lets intake and arithmetic stall separately.
// ----------------------------------------------------------------------------
module mhd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mhd_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output mhd_pkg::entry_type head
);
   import mhd_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;
   logic                do_pop;

   assign full      = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign head      = slot_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: design/mhd_mac.sv
// ----------------------------------------------------------------------------
// mhd_mac: complex multiply-accumulate
// Rotates each sample by its twiddle, weights it and adds it into the
// saturating frame sums; hands the sums on after the last sample.
// ----------------------------------------------------------------------------
module mhd_mac (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               q_valid,
   input  mhd_pkg::entry_type q_data,
   output logic               pop,
   output logic               frame_valid,
   output mhd_pkg::frame_type frame_data
);
   import mhd_pkg::*;

   logic                     s1_valid_ff;
   logic                     s1_dbl_ff;
   logic                     s1_last_ff;
   logic signed [PROD_W-1:0] p_byc_ff;
   logic signed [PROD_W-1:0] p_bxs_ff;
   logic signed [PROD_W-1:0] p_bxc_ff;
   logic signed [PROD_W-1:0] p_bys_ff;
   logic                     s2_valid_ff;
   logic                     s2_dbl_ff;
   logic                     s2_last_ff;
   logic signed [SUM_W-1:0]  re_ff;
   logic signed [SUM_W-1:0]  im_ff;
   logic signed [ACC_W-1:0]  acc_real_ff;
   logic signed [ACC_W-1:0]  acc_imag_ff;
   logic signed [ACC_W-1:0]  acc_real_in;
   logic signed [ACC_W-1:0]  acc_imag_in;
   logic signed [ACC_W-1:0]  sat_real;
   logic signed [ACC_W-1:0]  sat_imag;
   logic signed [TERM_W-1:0] term_real;
   logic signed [TERM_W-1:0] term_imag;
   logic signed [ACC_W:0]    sum_real;
   logic signed [ACC_W:0]    sum_imag;
   logic                     frame_valid_ff;
   frame_type                frame_ff;

   assign pop         = adv && q_valid;
   assign frame_valid = frame_valid_ff;
   assign frame_data  = frame_ff;

   // Stage one: the four partial products of the complex rotation.
   always_ff @(posedge clock) begin
      if (adv) begin
         p_byc_ff   <= PROD_W'(q_data.by) * PROD_W'(q_data.tw_cos);
         p_bxs_ff   <= PROD_W'(q_data.bx) * PROD_W'(q_data.tw_sin);
         p_bxc_ff   <= PROD_W'(q_data.bx) * PROD_W'(q_data.tw_cos);
         p_bys_ff   <= PROD_W'(q_data.by) * PROD_W'(q_data.tw_sin);
         s1_dbl_ff  <= q_data.dbl;
         s1_last_ff <= q_data.last;
      end
   end

   // Stage two: real and imaginary parts of the rotated sample.
   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff      <= SUM_W'(p_byc_ff) + SUM_W'(p_bxs_ff);
         im_ff      <= SUM_W'(p_bxc_ff) - SUM_W'(p_bys_ff);
         s2_dbl_ff  <= s1_dbl_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage three: weighted add with saturation. Interior samples count twice.
   always_comb begin
      term_real = s2_dbl_ff ? {re_ff, 1'b0} : TERM_W'(re_ff);
      term_imag = s2_dbl_ff ? {im_ff, 1'b0} : TERM_W'(im_ff);
      sum_real  = (ACC_W + 1)'(acc_real_ff) + (ACC_W + 1)'(term_real);
      sum_imag  = (ACC_W + 1)'(acc_imag_ff) + (ACC_W + 1)'(term_imag);
      if (sum_real[ACC_W] != sum_real[ACC_W-1]) begin
         sat_real = sum_real[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_real = sum_real[ACC_W-1:0];
      end
      if (sum_imag[ACC_W] != sum_imag[ACC_W-1]) begin
         sat_imag = sum_imag[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_imag = sum_imag[ACC_W-1:0];
      end
      acc_real_in = acc_real_ff;
      acc_imag_in = acc_imag_ff;
      if (adv && s2_valid_ff) begin
         acc_real_in = s2_last_ff ? '0 : sat_real;
         acc_imag_in = s2_last_ff ? '0 : sat_imag;
      end
   end

   // The finished sums leave together with the last sample of the frame.
   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff && s2_last_ff) begin
         frame_ff.sum_real <= sat_real;
         frame_ff.sum_imag <= sat_imag;
      end
   end

   // Valid chain and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         frame_valid_ff <= 1'b0;
         acc_real_ff    <= '0;
         acc_imag_ff    <= '0;
      end else begin
         acc_real_ff <= acc_real_in;
         acc_imag_ff <= acc_imag_in;
         if (adv) begin
            s1_valid_ff    <= q_valid;
            s2_valid_ff    <= s1_valid_ff;
            frame_valid_ff <= s2_valid_ff && s2_last_ff;
         end
      end
   end

endmodule

FILE: design/mhd_scale.sv
// ----------------------------------------------------------------------------
// mhd_scale: frame sum scaling and result register
// Divides both frame sums by 2*NSPAN*2^15 with rounding half away from zero,
// saturates to the output range and holds the result beat.
// ----------------------------------------------------------------------------
module mhd_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               frame_valid,
   input  mhd_pkg::frame_type frame_data,
   output logic               adv,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mhd_pkg::rsp_type   rsp_data
);
   import mhd_pkg::*;

   // Lane zero carries the imaginary sum (an), lane one the real sum (bn).
   logic [1:0][ACC_W-1:0]  lane_sum;
   logic [1:0]             f1_neg_in;
   logic [1:0][QUOT_W-1:0] f1_val_in;
   logic [1:0]             f1_neg_ff;
   logic [1:0][QUOT_W-1:0] f1_val_ff;
   logic [1:0][QUOT_W-1:0] f2_quot_in;
   logic [1:0]             f2_neg_ff;
   logic [1:0][QUOT_W-1:0] f2_val_ff;
   logic [1:0][QUOT_W-1:0] f2_quot_ff;
   logic [1:0][QUOT_W-1:0] f3_quot_in;
   logic [1:0]             f3_neg_ff;
   logic [1:0][QUOT_W-1:0] f3_quot_ff;
   logic [1:0][OUT_W-1:0]  out_in;
   logic                   f1_valid_ff;
   logic                   f2_valid_ff;
   logic                   f3_valid_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_open;
   rsp_type                rsp_ff;

   // The result register takes a new beat unless the consumer holds the current one.
   // The rest of the back end only stops when a finished result waits behind it.
   assign rsp_open  = !(rsp_valid_ff && rsp_stall);
   assign adv       = rsp_open || !f3_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign lane_sum  = {frame_data.sum_real, frame_data.sum_imag};

   // Per-lane arithmetic of all scaling steps.
   always_comb begin
      logic [ACC_W-1:0]    mag;
      logic [ACC_W-1:0]    rsum;
      logic [2*QUOT_W-1:0] prod;
      logic [QUOT_W-1:0]   rem;
      for (int i = 0; i < 2; i++) begin
         // Magnitude plus half the divisor, then the power-of-two part.
         f1_neg_in[i] = lane_sum[i][ACC_W-1];
         mag          = f1_neg_in[i] ? ACC_W'(-lane_sum[i]) : lane_sum[i];
         rsum         = mag + RND_BIAS;
         f1_val_in[i] = rsum[ACC_W-1:RND_SHIFT];
         // Quotient estimate by the reciprocal, low by at most one.
         prod          = (2*QUOT_W)'(f1_val_ff[i]) * (2*QUOT_W)'(RECIP);
         f2_quot_in[i] = prod[2*QUOT_W-1:QUOT_W];
         // Correct the estimate with the remainder.
         rem           = f2_val_ff[i] - f2_quot_ff[i] * SPAN_Q;
         f3_quot_in[i] = (rem >= SPAN_Q) ? f2_quot_ff[i] + 1'b1 : f2_quot_ff[i];
         // Restore the sign and saturate.
         if (f3_neg_ff[i]) begin
            if (f3_quot_ff[i] >= OUT_NEG_LIM) begin
               out_in[i] = OUT_NEG_LIM[OUT_W-1:0];
            end else begin
               out_in[i] = -f3_quot_ff[i][OUT_W-1:0];
            end
         end else begin
            if (f3_quot_ff[i] > OUT_POS_LIM) begin
               out_in[i] = OUT_POS_LIM[OUT_W-1:0];
            end else begin
               out_in[i] = f3_quot_ff[i][OUT_W-1:0];
            end
         end
      end
   end

   // Scaling pipeline.
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_neg_ff  <= f1_neg_in;
         f1_val_ff  <= f1_val_in;
         f2_neg_ff  <= f1_neg_ff;
         f2_val_ff  <= f1_val_ff;
         f2_quot_ff <= f2_quot_in;
         f3_neg_ff  <= f2_neg_ff;
         f3_quot_ff <= f3_quot_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (rsp_open) begin
         rsp_ff.an_coef <= out_in[0];
         rsp_ff.bn_coef <= out_in[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            f1_valid_ff <= frame_valid;
            f2_valid_ff <= f1_valid_ff;
            f3_valid_ff <= f2_valid_ff;
         end
         if (rsp_open) begin
            rsp_valid_ff <= f3_valid_ff;
         end
      end
   end

endmodule

FILE: design/multipole_harmonic_dft.sv
// Throughput: one sample beat per cycle; a held result slows intake only when the
// next frame's result is already waiting in the last scaling stage behind it.
// After the last sample of a frame is accepted, its result beat passes the queue,
// three MAC stages, three scaling stages and the result register to rsp_valid.
// Reset is synchronous, active high: it empties the queue, clears the sums,
// restarts the frame at sample zero and sets the harmonic order to one.
// ----------------------------------------------------------------------------
// multipole_harmonic_dft: single-bin trapezoidal DFT of a sampled circle
// Accumulates (by + j*bx) * exp(-j*(n-1)*theta) over one frame of samples and
// returns the scaled skew (an) and normal (bn) coefficients.
// ----------------------------------------------------------------------------
module multipole_harmonic_dft (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mhd_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mhd_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  mhd_pkg::order_type csr_data
);
   import mhd_pkg::*;

   logic      push;
   entry_type push_data;
   logic      queue_full;
   logic      queue_not_empty;
   entry_type queue_head;
   logic      pop;
   logic      adv;
   logic      frame_valid;
   frame_type frame_data;

   // Intake and classification.
   mhd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Decoupling queue.
   mhd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // Multiply-accumulate.
   mhd_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .q_valid     (queue_not_empty),
      .q_data      (queue_head),
      .pop         (pop),
      .frame_valid (frame_valid),
      .frame_data  (frame_data)
   );

   // Scaling and result register.
   mhd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_data  (frame_data),
      .adv         (adv),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: design/mhd_checker.sv
// ----------------------------------------------------------------------------
// mhd_checker: port-level checks of the harmonic DFT block
// Counts finished frames at the input and checks that results match them,
// that reset leaves the block ready, and that a held result stays put.
// ----------------------------------------------------------------------------
module mhd_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mhd_pkg::rsp_type rsp_data
);
   import mhd_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [3:0]       pending_ff;
   logic             req_beat;
   logic             rsp_beat;
   logic             frame_end;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign frame_end = req_beat && (count_ff == CNT_W'(NSPAN));

   // Track the frame position and the frames still owed a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         if (req_beat) begin
            count_ff <= frame_end ? '0 : count_ff + 1'b1;
         end
         if (frame_end && !rsp_beat) begin
            pending_ff <= pending_ff + 1'b1;
         end else if (rsp_beat && !frame_end) begin
            pending_ff <= pending_ff - 1'b1;
         end
      end
   end

   // Reset leaves no result pending and the input open.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending or input stalled after reset");

   // Every result beat answers a frame whose last sample was taken.
   a_result_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("result beat without a completed frame");

   // A held result beat stays valid and unchanged.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result beat dropped or changed");

endmodule

bind multipole_harmonic_dft mhd_port_checks u_checker (.*);

FILE: test/mhd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mhd_checker: coefficient predictor and scoreboard for the harmonic DFT
// Watches the sample, coefficient and order channels. Every sample beat is
// folded into a bit-exact copy of the frame sums, and each finished frame
// queues the expected an/bn pair. Coefficient beats are checked against the
// oldest queued pair.
// ----------------------------------------------------------------------------
module mhd_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  mhd_pkg::req_type   req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  mhd_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  mhd_pkg::order_type csr_data,
   output int                 error_count,
   output int                 pending_results
);

   localparam int              SPAN         = mhd_pkg::NSPAN;
   localparam longint unsigned Q30_ONE      = 64'd1073741824;
   localparam longint unsigned QUARTER_PI   = 64'd843314857;
   localparam longint          SUM_HI       = 64'sd140737488355327;
   localparam longint          SUM_LO       = -64'sd140737488355328;
   localparam longint          COEF_HI      = 64'sd8388607;
   localparam longint          COEF_LO      = -64'sd8388608;
   localparam int              REPORT_LIMIT = 10;

   // Shadow of the block state: doubled frame sums, sample index, phase, order.
   longint sum_re;
   longint sum_im;
   int     k_next;
   int     phase_next;
   int     order_now;
   int     errors;

   mhd_pkg::rsp_type coef_expected[$];

   // Round a Q30 magnitude to Q15, half up, clipped below one.
   function automatic int q15_round(input longint unsigned v);
      longint unsigned r;
      r = (v + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return int'(r);
   endfunction

   // Cosine and sine of 2*pi*p/SPAN: octant reduction, then Taylor series.
   function automatic void rotor(input int p, output int cv, output int sv);
      longint unsigned q;
      longint unsigned r;
      longint unsigned rr;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      int oct;
      int cs;
      int sn;
      q   = 8 * p;
      oct = int'((q / SPAN) & 64'd7);
      r   = q % SPAN;
      rr  = (oct % 2 == 1) ? SPAN - r : r;
      x   = (QUARTER_PI * rr + SPAN / 2) / SPAN;
      x2  = (x * x) >> 30;
      t   = Q30_ONE - x2 / 42;
      t   = Q30_ONE - ((x2 * t) >> 30) / 20;
      t   = Q30_ONE - ((x2 * t) >> 30) / 6;
      sn  = q15_round((x * t) >> 30);
      t   = Q30_ONE - x2 / 30;
      t   = Q30_ONE - ((x2 * t) >> 30) / 12;
      cs  = q15_round(Q30_ONE - ((x2 * t) >> 30) / 2);
      case (oct)
         0: begin cv = cs;  sv = sn;  end
         1: begin cv = sn;  sv = cs;  end
         2: begin cv = -sn; sv = cs;  end
         3: begin cv = -cs; sv = sn;  end
         4: begin cv = -cs; sv = -sn; end
         5: begin cv = -sn; sv = -cs; end
         6: begin cv = sn;  sv = -cs; end
         default: begin cv = cs; sv = -sn; end
      endcase
   endfunction

   function automatic longint clamp_sum(input longint v);
      if (v > SUM_HI) begin
         return SUM_HI;
      end
      if (v < SUM_LO) begin
         return SUM_LO;
      end
      return v;
   endfunction

   // Divide a doubled sum by 2*SPAN*2^15, ties away from zero, then saturate.
   function automatic logic signed [23:0] scale_coef(input longint a);
      longint unsigned d;
      longint unsigned mag;
      longint unsigned qv;
      longint v;
      d   = 2 * SPAN * 32768;
      mag = (a < 0) ? -a : a;
      qv  = (mag + d / 2) / d;
      v   = (a < 0) ? -$signed(qv) : $signed(qv);
      if (v > COEF_HI) begin
         v = COEF_HI;
      end
      if (v < COEF_LO) begin
         v = COEF_LO;
      end
      return 24'(v);
   endfunction

   // Fold one sample beat into the sums; the last sample of a frame yields a pair.
   task automatic take_sample(input mhd_pkg::req_type beat);
      longint bx;
      longint by;
      longint re;
      longint im;
      longint w;
      int c;
      int s;
      bit last;
      mhd_pkg::rsp_type coef;
      bx   = longint'($signed(beat.bx_sample));
      by   = longint'($signed(beat.by_sample));
      last = (k_next >= SPAN);
      rotor(phase_next % SPAN, c, s);
      re = by * c + bx * s;
      im = bx * c - by * s;
      w  = (k_next == 0 || last) ? 1 : 2;
      sum_re = clamp_sum(sum_re + w * re);
      sum_im = clamp_sum(sum_im + w * im);
      if (last) begin
         coef.an_coef = scale_coef(sum_im);
         coef.bn_coef = scale_coef(sum_re);
         coef_expected = {coef_expected, coef};
         sum_re     = 0;
         sum_im     = 0;
         k_next     = 0;
         phase_next = 0;
      end else begin
         k_next++;
         phase_next = (phase_next % SPAN + (order_now + SPAN - 1) % SPAN) % SPAN;
      end
   endtask

   task automatic flag_field(input string field, input longint want, input longint got);
      if (errors < REPORT_LIMIT) begin
         $display("%0t mhd_checker: %s expected %0d got %0d", $time, field, want, got);
      end
      errors++;
   endtask

   // Track every accepted beat at the clock edge that accepts it.
   always @(posedge clock) begin
      mhd_pkg::rsp_type coef;
      if (reset) begin
         sum_re     = 0;
         sum_im     = 0;
         k_next     = 0;
         phase_next = 0;
         order_now  = 1;
         errors     = 0;
         coef_expected.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            order_now = int'(csr_data);
         end
         if (req_valid && !req_stall) begin
            take_sample(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (coef_expected.size() == 0) begin
               if (errors < REPORT_LIMIT) begin
                  $display("%0t mhd_checker: coefficient beat an=%0d bn=%0d, expected none",
                           $time, $signed(rsp_data.an_coef), $signed(rsp_data.bn_coef));
               end
               errors++;
            end else begin
               coef = coef_expected.pop_front();
               if (rsp_data.an_coef !== coef.an_coef) begin
                  flag_field("an_coef", longint'($signed(coef.an_coef)),
                             longint'($signed(rsp_data.an_coef)));
               end
               if (rsp_data.bn_coef !== coef.bn_coef) begin
                  flag_field("bn_coef", longint'($signed(coef.bn_coef)),
                             longint'($signed(rsp_data.bn_coef)));
               end
            end
         end
      end
      error_count     <= errors;
      pending_results <= coef_expected.size();
   end

endmodule

FILE: test/tb_multipole_harmonic_dft.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multipole_harmonic_dft: stimulus and verdict for the harmonic DFT block
// Sends extreme sample pairs, then random frames and partial frames under
// changing harmonic orders, including frames whose samples follow the twiddle
// signs so that bn saturates. The sample side sends in bursts,
// the coefficient side stalls on its own pattern, and the checker beside the
// block predicts and compares every coefficient beat.
// ----------------------------------------------------------------------------
module tb_multipole_harmonic_dft;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int FRAME_LEN     = mhd_pkg::NSAMPLES;
   localparam int RANDOM_ITEMS  = 1350;
   // A frame's result passes the queue, MAC and scaling stages and result register; its queue holds four.
   localparam int FLUSH_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 24;
   // The longest quiet stretch of a correct run comes from long stalls, burst gaps
   // and flush pauses; this limit allows many times that.
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [23:0] FIELD_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] FIELD_MIN = 24'sh800000;

   typedef enum int {FILL_FULL, FILL_CORNER, FILL_SMALL} fill_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   mhd_pkg::req_type   req_data;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   mhd_pkg::rsp_type   rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   mhd_pkg::order_type csr_data;

   int error_count;
   int pending_results;

   int        burst_left   = 0;
   bit        gaps_on      = 1'b1;
   int        frame_pos    = 0;
   int        sent_random  = 0;
   int        idle_cycles  = 0;
   stall_type stall_mode   = STALL_NONE;
   int        mode_left    = 0;
   int        hold_left    = 0;

   always #HALF_PERIOD clock = ~clock;

   multipole_harmonic_dft DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   mhd_checker coef_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   // Coefficient side: stall pattern that switches between modes every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 300);
         end
         mode_left--;
         case (stall_mode)
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 1) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_LONG: begin
               if (hold_left > 0) begin
                  hold_left--;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 15) == 0) begin
                  hold_left = $urandom_range(5, 30);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Watchdog: too many cycles without any beat on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_multipole_harmonic_dft: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one sample beat, opening a new burst when due, after a random gap if gaps are on.
   task automatic send_sample(input logic signed [23:0] bx, input logic signed [23:0] by);
      int gap;
      mhd_pkg::req_type beat;
      if (burst_left == 0) begin
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      beat.bx_sample = bx;
      beat.by_sample = by;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      frame_pos = (frame_pos == FRAME_LEN - 1) ? 0 : frame_pos + 1;
   endtask

   // Hold off until every coefficient has come and the sample queue has drained.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input int n);
      csr_valid <= 1'b1;
      csr_data  <= mhd_pkg::order_type'(n);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [23:0] pick_field(input fill_type fill);
      logic signed [23:0] v;
      case (fill)
         FILL_CORNER: begin
            case ($urandom_range(0, 5))
               0: v = FIELD_MAX;
               1: v = FIELD_MIN;
               2: v = '0;
               3: v = 24'sd1;
               4: v = -24'sd1;
               default: v = 24'($urandom);
            endcase
         end
         FILL_SMALL: v = 24'($urandom_range(0, 8191)) - 24'sd4096;
         default: v = 24'($urandom);
      endcase
      return v;
   endfunction

   initial begin
      logic signed [23:0] dir_bx [0:19];
      logic signed [23:0] dir_by [0:19];
      int  count;
      int  ph;
      bit  polarity;
      bit  cos_pos;
      bit  sin_pos;
      fill_type fill;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes under the reset order, whose twiddle is the clipped unit.
      dir_bx = '{FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, 24'sd0, 24'sd1, -24'sd1,
                 24'sd0, FIELD_MAX, 24'sd0, FIELD_MIN, 24'sh555555, 24'shAAAAAA,
                 24'sd1, -24'sd1, FIELD_MAX, FIELD_MIN, 24'sh000001, 24'sh7FFFFE,
                 24'sh800001};
      dir_by = '{FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX, 24'sd0, -24'sd1, 24'sd1,
                 FIELD_MAX, 24'sd0, FIELD_MIN, 24'sd0, 24'shAAAAAA, 24'sh555555,
                 24'sd1, -24'sd1, FIELD_MAX, FIELD_MIN, 24'sh800001, 24'sh7FFFFE,
                 24'sh000001};
      for (int i = 0; i < 20; i++) begin
         send_sample(dir_bx[i], dir_by[i]);
      end

      // Random phases; each order write lands between samples, often mid-frame.
      while (sent_random < RANDOM_ITEMS) begin
         settle();
         gaps_on = ($urandom_range(0, 3) != 0);
         if (frame_pos == 0 && $urandom_range(0, 5) == 0) begin
            // Whole frame at order two with samples matched to the twiddle signs,
            // which drives the bn coefficient past its limit.
            write_order(2);
            polarity = $urandom_range(0, 1);
            for (int k = 0; k < FRAME_LEN; k++) begin
               ph      = k % (FRAME_LEN - 1);
               cos_pos = (ph <= 12 || ph >= 38);
               sin_pos = (ph <= 24);
               send_sample((sin_pos ^ polarity) ? FIELD_MAX : FIELD_MIN,
                           (cos_pos ^ polarity) ? FIELD_MAX : FIELD_MIN);
               sent_random++;
            end
         end else begin
            case ($urandom_range(0, 6))
               0: write_order(1);
               1: write_order(25);
               2: write_order(0);
               3: write_order(31);
               4: write_order(26);
               5: write_order(2);
               default: write_order($urandom_range(0, 31));
            endcase
            fill  = fill_type'($urandom_range(0, 2));
            count = $urandom_range(1, 120);
            for (int i = 0; i < count; i++) begin
               send_sample(pick_field(fill), pick_field(fill));
               sent_random++;
            end
         end
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("tb_multipole_harmonic_dft: done, clean");
      end else begin
         $display("tb_multipole_harmonic_dft: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/mhd_pkg.sv
design/mhd_front.sv
design/mhd_queue.sv
design/mhd_mac.sv
design/mhd_scale.sv
design/multipole_harmonic_dft.sv
design/mhd_checker.sv
test/mhd_checker.sv
test/tb_multipole_harmonic_dft.sv
